@@ src/tcce_pkg.sv @@
// Shared constants, codes and widths of the text console cell engine.
package tcce_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;

	localparam int CMD_W    = 3;
	localparam int CHAR_W   = 8;
	localparam int COLARG_W = 8;
	localparam int ROWARG_W = 6;
	localparam int X_W      = 7;
	localparam int Y_W      = 5;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);

	localparam logic [CMD_W-1:0] CMD_PUT_CHAR     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SET_CURSOR   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR_LINE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR_SCREEN = 3'd3;
	localparam logic [CMD_W-1:0] CMD_HOME         = 3'd4;
	localparam logic [CMD_W-1:0] CMD_BACKSPACE    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR_END    = 3'd6;
	localparam logic [CMD_W-1:0] CMD_READ_CELL    = 3'd7;

	localparam logic [CHAR_W-1:0] BLANK  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
	localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
	localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

	localparam logic [X_W-1:0] TAB_MASK = 7'd7;

endpackage

@@ src/tcce_req_if.sv @@
// Command channel of the text console cell engine.
interface tcce_req_if;
	logic                         valid;
	logic                         ready;
	logic [tcce_pkg::CMD_W-1:0]    command;
	logic [tcce_pkg::CHAR_W-1:0]   char_code;
	logic [tcce_pkg::COLARG_W-1:0] col_arg;
	logic [tcce_pkg::ROWARG_W-1:0] row_arg;

	modport source (output valid, command, char_code, col_arg, row_arg, input ready);
	modport sink (input valid, command, char_code, col_arg, row_arg, output ready);
endinterface

@@ src/tcce_rsp_if.sv @@
// Result channel of the text console cell engine.
interface tcce_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [tcce_pkg::X_W-1:0]    cursor_col;
	logic [tcce_pkg::Y_W-1:0]    cursor_row;
	logic [tcce_pkg::CHAR_W-1:0] cell_char;

	modport source (output valid, cursor_col, cursor_row, cell_char, input ready);
	modport sink (input valid, cursor_col, cursor_row, cell_char, output ready);
endinterface

@@ src/tcce_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module tcce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ src/text_console_cell_engine_top.sv @@
// Top level of the text console cell engine: command sequencer around the screen RAM.
//
// An 80 by 25 character screen held in one RAM, one cell per entry, with a 1-based
// cursor. Scrolling rotates a top-row offset and blanks one row, so it costs one
// row of writes. Each command is taken on the req channel and answered by exactly
// one rsp transaction. CR, backspace, set cursor, home, LF without a scroll, a read
// outside the screen and a line clear with a wrap pending go straight to the result;
// a printable byte or a tab writes through S_WRITE, a tab one space per step, and a
// printable byte or tab that starts at a pending wrap wraps there first; a read
// inside the screen passes S_LATCH. Any command that clears cells or scrolls
// blanks its cells in S_SWEEP (80 per scrolled row, 2000 for a clear screen),
// one at a time, since the RAM write port takes one cell a cycle. After reset a
// clearing pass fills the screen with spaces, with req.ready low.
// One command is in flight at a time; the result register lets the next command
// be accepted while the previous result waits.
module text_console_cell_engine_top (
	input logic   clk,
	input logic   arst_n,
	tcce_req_if.sink   req,
	tcce_rsp_if.source rsp
);
	import tcce_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_WRITE  = 3'd1;
	localparam logic [2:0] S_SWEEP  = 3'd2;
	localparam logic [2:0] S_LATCH  = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	localparam logic [1:0] RET_FINISH = 2'd0;
	localparam logic [1:0] RET_WRITE  = 2'd1;
	localparam logic [1:0] RET_IDLE   = 2'd2;

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

	logic [2:0]        state_q;
	logic [1:0]        ret_q;
	logic [X_W-1:0]    x_q;
	logic [Y_W-1:0]    y_q;
	logic [ROW_W-1:0]  top_q;
	logic [ROW_W-1:0]  sw_row_q;
	logic [COL_W-1:0]  sw_col_q;
	logic [ROW_W-1:0]  sw_last_q;
	logic [CHAR_W-1:0] char_q;
	logic              tab_q;
	logic [CHAR_W-1:0] cell_q;

	logic              rsp_valid_q;
	logic [X_W-1:0]    rsp_col_q;
	logic [Y_W-1:0]    rsp_row_q;
	logic [CHAR_W-1:0] rsp_cell_q;

	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [CHAR_W-1:0] wdata;
	logic [CHAR_W-1:0] rdata;
	logic              accept;
	logic              read_ok;
	logic [ROW_W-1:0]  top_next;
	logic [ROW_W-1:0]  cur_row;
	logic [COL_W-1:0]  cur_col;
	logic              out_free;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] lrow,
			input logic [COL_W-1:0] col, input logic [ROW_W-1:0] top);
		logic [ROW_W:0] phys;
		phys = {1'b0, lrow} + {1'b0, top};
		if (phys >= (ROW_W+1)'(ROWS)) begin
			phys = phys - (ROW_W+1)'(ROWS);
		end
		return ADDR_W'(phys * ADDR_W'(COLUMNS)) + ADDR_W'(col);
	endfunction

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign read_ok  = (req.col_arg < COLARG_W'(COLUMNS)) && (req.row_arg < ROWARG_W'(ROWS));
	assign top_next = (top_q == LAST_ROW) ? '0 : top_q + 1'b1;
	assign cur_row  = ROW_W'(y_q - 1'b1);
	assign cur_col  = COL_W'(x_q - 1'b1);
	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		ram_we = 1'b0;
		waddr  = cell_addr(sw_row_q, sw_col_q, top_q);
		wdata  = BLANK;
		if (state_q == S_SWEEP) begin
			ram_we = 1'b1;
		end else if (state_q == S_WRITE && x_q <= X_W'(COLUMNS)) begin
			ram_we = 1'b1;
			waddr  = cell_addr(cur_row, cur_col, top_q);
			wdata  = char_q;
		end
	end

	assign ram_re = accept && req.command == CMD_READ_CELL && read_ok;
	assign raddr  = cell_addr(ROW_W'(req.row_arg), COL_W'(req.col_arg), top_q);

	tcce_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SWEEP;
			ret_q     <= RET_IDLE;
			x_q       <= X_W'(1);
			y_q       <= Y_W'(1);
			top_q     <= '0;
			sw_row_q  <= '0;
			sw_col_q  <= '0;
			sw_last_q <= LAST_ROW;
			tab_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_FINISH;
						tab_q   <= 1'b0;
						ret_q   <= RET_FINISH;
						case (req.command)
							CMD_PUT_CHAR: begin
								if (req.char_code == CH_CR) begin
									x_q <= X_W'(1);
								end else if (req.char_code == CH_BS) begin
									if (x_q > X_W'(1)) begin
										x_q <= x_q - 1'b1;
									end
								end else if (req.char_code == CH_LF) begin
									x_q <= X_W'(1);
									if (y_q == Y_W'(ROWS)) begin
										top_q     <= top_next;
										sw_row_q  <= LAST_ROW;
										sw_col_q  <= '0;
										sw_last_q <= LAST_ROW;
										state_q   <= S_SWEEP;
									end else begin
										y_q <= y_q + 1'b1;
									end
								end else begin
									tab_q   <= (req.char_code == CH_TAB);
									state_q <= S_WRITE;
								end
							end
							CMD_SET_CURSOR: begin
								if (req.col_arg == '0) begin
									x_q <= X_W'(1);
								end else if (req.col_arg > COLARG_W'(COLUMNS)) begin
									x_q <= X_W'(COLUMNS);
								end else begin
									x_q <= X_W'(req.col_arg);
								end
								if (req.row_arg == '0) begin
									y_q <= Y_W'(1);
								end else if (req.row_arg > ROWARG_W'(ROWS)) begin
									y_q <= Y_W'(ROWS);
								end else begin
									y_q <= Y_W'(req.row_arg);
								end
							end
							CMD_CLEAR_LINE: begin
								if (x_q <= X_W'(COLUMNS)) begin
									sw_row_q  <= cur_row;
									sw_col_q  <= cur_col;
									sw_last_q <= cur_row;
									state_q   <= S_SWEEP;
								end
							end
							CMD_CLEAR_SCREEN: begin
								x_q       <= X_W'(1);
								y_q       <= Y_W'(1);
								sw_row_q  <= '0;
								sw_col_q  <= '0;
								sw_last_q <= LAST_ROW;
								state_q   <= S_SWEEP;
							end
							CMD_HOME: begin
								x_q <= X_W'(1);
								y_q <= Y_W'(1);
							end
							CMD_BACKSPACE: begin
								if (x_q > X_W'(1)) begin
									x_q <= x_q - 1'b1;
								end
							end
							CMD_CLEAR_END: begin
								sw_row_q  <= cur_row;
								sw_col_q  <= (x_q > X_W'(COLUMNS)) ? LAST_COL : cur_col;
								sw_last_q <= LAST_ROW;
								state_q   <= S_SWEEP;
							end
							default: begin
								if (read_ok) begin
									state_q <= S_LATCH;
								end
							end
						endcase
					end
				end
				S_WRITE: begin
					if (x_q > X_W'(COLUMNS)) begin
						x_q <= X_W'(1);
						if (y_q == Y_W'(ROWS)) begin
							top_q     <= top_next;
							sw_row_q  <= LAST_ROW;
							sw_col_q  <= '0;
							sw_last_q <= LAST_ROW;
							ret_q     <= RET_WRITE;
							state_q   <= S_SWEEP;
						end else begin
							y_q <= y_q + 1'b1;
						end
					end else begin
						x_q <= x_q + 1'b1;
						if (!(tab_q && (x_q & TAB_MASK) != '0)) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SWEEP: begin
					if (sw_col_q == LAST_COL) begin
						if (sw_row_q == sw_last_q) begin
							case (ret_q)
								RET_WRITE: state_q <= S_WRITE;
								RET_IDLE:  state_q <= S_IDLE;
								default:   state_q <= S_FINISH;
							endcase
						end else begin
							sw_row_q <= sw_row_q + 1'b1;
							sw_col_q <= '0;
						end
					end else begin
						sw_col_q <= sw_col_q + 1'b1;
					end
				end
				S_LATCH: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= (req.char_code == CH_TAB) ? BLANK : req.char_code;
			cell_q <= '0;
		end else if (state_q == S_LATCH) begin
			cell_q <= rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			rsp_col_q  <= x_q;
			rsp_row_q  <= y_q;
			rsp_cell_q <= cell_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.cursor_col = rsp_col_q;
	assign rsp.cursor_row = rsp_row_q;
	assign rsp.cell_char  = rsp_cell_q;

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		x_q >= X_W'(1) && x_q <= X_W'(COLUMNS + 1) && y_q >= Y_W'(1) && y_q <= Y_W'(ROWS))
		else $error("cursor out of range");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SWEEP |-> sw_row_q <= sw_last_q && sw_last_q <= LAST_ROW
			&& sw_col_q <= LAST_COL && top_q <= LAST_ROW)
		else $error("sweep or offset out of range");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("second transaction accepted while one is in flight");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH && out_free |=> rsp_valid_q && state_q == S_IDLE)
		else $error("result not loaded on finish");
endmodule
